@@ design/echt_pkg.sv @@
`default_nettype none

package echt_pkg;

  // Status register bits
  localparam logic [7:0] ST_OBF_MASK = 8'h01;
  localparam logic [7:0] ST_IBF_MASK = 8'h02;

  // Controller commands
  localparam logic [7:0] CMD_READ  = 8'h80;
  localparam logic [7:0] CMD_WRITE = 8'h81;

  // Configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_COMMAND_PORT = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DATA_PORT    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_BIG_ENDIAN   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_RETRY_LIMIT  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_POLL_LIMIT   = 3'd4;

  // Result queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_DONE  = 2'd2
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  port;
    logic [7:0]  out_byte;
    logic        ok;
    logic [15:0] read_value;
    logic        last;
  } result_t;

  function automatic result_t make_res(action_e act, logic [7:0] port, logic [7:0] b,
                                       logic ok, logic [15:0] val);
    result_t r;
    r.action     = act;
    r.port       = port;
    r.out_byte   = b;
    r.ok         = ok;
    r.read_value = val;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ec_host_transaction_engine.sv @@
`default_nettype none

// Host-side engine for the embedded-controller command/data port handshake. Each input beat
// (a new request, or the byte returned by the last requested port read) is decoded combinationally
// and yields zero, one or two result beats (port read, port write, or request
// completion), which are pushed into a four-entry result queue. An input beat is taken in
// any cycle the queue has room for two results, so one input beat per cycle is sustained
// as long as the output side drains one result per cycle; beats that yield two results
// need both of them drained, and the output rate of one beat per cycle is the limit.
// Requests that arrive while a request is in flight, and port bytes while idle, are
// dropped silently. Configuration may only be written while the engine is idle.
module ec_host_transaction_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] is_write, [1] is_word, [9:2] reg_addr, [25:10] write_value,
  // [33:26] response_byte, [39:34] zero
  input  wire logic [39:0] s_axis_tdata,
  // [0] kind
  input  wire logic        s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] port, [15:8] out_byte, [16] ok, [32:17] read_value, [39:33] zero
  output logic [39:0]      m_axis_tdata,
  // [1:0] action
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_IBF_CMD,
    PH_IBF_ADDR,
    PH_IBF_DATA,
    PH_OBF,
    PH_DATA
  } phase_e;

  // Configuration
  logic [7:0]  command_port_q, data_port_q, retry_limit_q;
  logic        big_endian_q;
  logic [15:0] poll_limit_q;

  // Transaction state
  phase_e      phase_q, phase_d;
  logic [15:0] poll_cnt_q, poll_cnt_d;
  logic [7:0]  attempt_q, attempt_d;
  logic        second_q, second_d;
  logic        held_write_q, held_write_d;
  logic        held_word_q, held_word_d;
  logic [7:0]  held_addr_q, held_addr_d;
  logic [15:0] held_value_q, held_value_d;
  logic [7:0]  first_byte_q, first_byte_d;

  // Result queue
  echt_pkg::result_t           q_mem [echt_pkg::Q_DEPTH];
  logic [echt_pkg::Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [echt_pkg::Q_AW:0]     count_q, count_d;

  // Input fields
  logic        in_kind, in_is_write, in_is_word;
  logic [7:0]  in_reg_addr, in_resp;
  logic [15:0] in_write_value;

  assign in_kind        = s_axis_tuser;
  assign in_is_write    = s_axis_tdata[0];
  assign in_is_word     = s_axis_tdata[1];
  assign in_reg_addr    = s_axis_tdata[9:2];
  assign in_write_value = s_axis_tdata[25:10];
  assign in_resp        = s_axis_tdata[33:26];

  logic in_acc, out_acc;
  assign s_axis_tready = (count_q <= 3'(echt_pkg::Q_DEPTH - 2));
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Decode
  echt_pkg::result_t r0, r1, poll_res, begin_res, fin_res;
  logic [1:0]  n_res;
  logic        begin_fail, fin_first, do_finish, fin_slot, ready;
  logic [7:0]  fin_b, cur_addr, cur_wbyte, att_inc;
  logic [15:0] pc_inc, fin_val;

  always_comb begin
    poll_res   = echt_pkg::make_res(echt_pkg::ACT_READ, command_port_q, 8'h00, 1'b0, 16'h0000);
    begin_fail = (retry_limit_q == 8'h00) || (poll_limit_q == 16'h0000);
    begin_res  = begin_fail ?
                 echt_pkg::make_res(echt_pkg::ACT_DONE, 8'h00, 8'h00, 1'b0, 16'h0000) :
                 poll_res;
    cur_addr   = held_addr_q + {7'b0, second_q};
    cur_wbyte  = (held_word_q && (big_endian_q ^ second_q)) ? held_value_q[15:8] :
                                                                held_value_q[7:0];
    fin_b      = (phase_q == PH_DATA) ? in_resp : 8'h00;
    fin_first  = held_word_q && !second_q;
    if (held_write_q) begin
      fin_val = 16'h0000;
    end else if (!held_word_q) begin
      fin_val = {8'h00, fin_b};
    end else if (big_endian_q) begin
      fin_val = {first_byte_q, fin_b};
    end else begin
      fin_val = {fin_b, first_byte_q};
    end
    fin_res = fin_first ? begin_res :
              echt_pkg::make_res(echt_pkg::ACT_DONE, 8'h00, 8'h00, 1'b1, fin_val);
    pc_inc  = (poll_cnt_q == 16'hFFFF) ? poll_cnt_q : poll_cnt_q + 16'd1;
    att_inc = (attempt_q == 8'hFF) ? attempt_q : attempt_q + 8'd1;
    ready   = (phase_q == PH_OBF) ? ((in_resp & echt_pkg::ST_OBF_MASK) != 8'h00) :
                                    ((in_resp & echt_pkg::ST_IBF_MASK) == 8'h00);

    phase_d      = phase_q;
    poll_cnt_d   = poll_cnt_q;
    attempt_d    = attempt_q;
    second_d     = second_q;
    held_write_d = held_write_q;
    held_word_d  = held_word_q;
    held_addr_d  = held_addr_q;
    held_value_d = held_value_q;
    first_byte_d = first_byte_q;
    r0           = '0;
    r1           = '0;
    n_res        = 2'd0;
    do_finish    = 1'b0;
    fin_slot     = 1'b0;

    if (in_acc) begin
      if (!in_kind) begin
        if (phase_q == PH_IDLE) begin
          held_write_d = in_is_write;
          held_word_d  = in_is_word;
          held_addr_d  = in_reg_addr;
          held_value_d = in_write_value;
          second_d     = 1'b0;
          first_byte_d = 8'h00;
          attempt_d    = 8'h00;
          if (begin_fail) begin
            phase_d = PH_IDLE;
          end else begin
            poll_cnt_d = 16'h0000;
            phase_d    = PH_IBF_CMD;
          end
          r0    = begin_res;
          n_res = 2'd1;
        end
      end else if (phase_q == PH_DATA) begin
        do_finish = 1'b1;
        n_res     = 2'd1;
      end else if (phase_q != PH_IDLE) begin
        poll_cnt_d = pc_inc;
        if (ready) begin
          unique case (phase_q)
            PH_IBF_CMD: begin
              r0 = echt_pkg::make_res(echt_pkg::ACT_WRITE, command_port_q,
                                      held_write_q ? echt_pkg::CMD_WRITE : echt_pkg::CMD_READ,
                                      1'b0, 16'h0000);
              r1         = poll_res;
              n_res      = 2'd2;
              poll_cnt_d = 16'h0000;
              phase_d    = PH_IBF_ADDR;
            end
            PH_IBF_ADDR: begin
              r0 = echt_pkg::make_res(echt_pkg::ACT_WRITE, data_port_q, cur_addr,
                                      1'b0, 16'h0000);
              r1         = poll_res;
              n_res      = 2'd2;
              poll_cnt_d = 16'h0000;
              phase_d    = PH_IBF_DATA;
            end
            PH_IBF_DATA: begin
              if (held_write_q) begin
                r0 = echt_pkg::make_res(echt_pkg::ACT_WRITE, data_port_q, cur_wbyte,
                                        1'b0, 16'h0000);
                do_finish = 1'b1;
                fin_slot  = 1'b1;
                n_res     = 2'd2;
              end else begin
                r0         = poll_res;
                n_res      = 2'd1;
                poll_cnt_d = 16'h0000;
                phase_d    = PH_OBF;
              end
            end
            default: begin
              r0 = echt_pkg::make_res(echt_pkg::ACT_READ, data_port_q, 8'h00,
                                      1'b0, 16'h0000);
              n_res   = 2'd1;
              phase_d = PH_DATA;
            end
          endcase
        end else if (pc_inc >= poll_limit_q) begin
          attempt_d = att_inc;
          n_res     = 2'd1;
          if (att_inc >= retry_limit_q) begin
            phase_d = PH_IDLE;
            r0 = echt_pkg::make_res(echt_pkg::ACT_DONE, 8'h00, 8'h00, 1'b0, 16'h0000);
          end else begin
            poll_cnt_d = 16'h0000;
            phase_d    = PH_IBF_CMD;
            r0         = poll_res;
          end
        end else begin
          r0    = poll_res;
          n_res = 2'd1;
        end
      end
    end

    // Byte operation done: start the second byte of a word or complete the request
    if (do_finish) begin
      if (fin_first) begin
        first_byte_d = fin_b;
        second_d     = 1'b1;
        attempt_d    = 8'h00;
        if (begin_fail) begin
          phase_d = PH_IDLE;
        end else begin
          poll_cnt_d = 16'h0000;
          phase_d    = PH_IBF_CMD;
        end
      end else begin
        phase_d = PH_IDLE;
      end
      if (fin_slot) begin
        r1 = fin_res;
      end else begin
        r0 = fin_res;
      end
    end

    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
    count_d = count_q + {1'b0, n_res} - {2'b00, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_port_q <= 8'h66;
      data_port_q    <= 8'h62;
      big_endian_q   <= 1'b1;
      retry_limit_q  <= 8'd5;
      poll_limit_q   <= 16'd100;
      phase_q        <= PH_IDLE;
      poll_cnt_q     <= '0;
      attempt_q      <= '0;
      second_q       <= 1'b0;
      held_write_q   <= 1'b0;
      held_word_q    <= 1'b0;
      held_addr_q    <= '0;
      held_value_q   <= '0;
      first_byte_q   <= '0;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
      count_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_addr_i)
          echt_pkg::CFG_COMMAND_PORT: command_port_q <= cfg_data_i[7:0];
          echt_pkg::CFG_DATA_PORT:    data_port_q    <= cfg_data_i[7:0];
          echt_pkg::CFG_BIG_ENDIAN:   big_endian_q   <= cfg_data_i[0];
          echt_pkg::CFG_RETRY_LIMIT:  retry_limit_q  <= cfg_data_i[7:0];
          echt_pkg::CFG_POLL_LIMIT:   poll_limit_q   <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q      <= phase_d;
      poll_cnt_q   <= poll_cnt_d;
      attempt_q    <= attempt_d;
      second_q     <= second_d;
      held_write_q <= held_write_d;
      held_word_q  <= held_word_d;
      held_addr_q  <= held_addr_d;
      held_value_q <= held_value_d;
      first_byte_q <= first_byte_d;
      wr_ptr_q     <= wr_ptr_q + n_res;
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      q_mem[wr_ptr_q] <= r0;
    end
    if (n_res == 2'd2) begin
      q_mem[wr_ptr_q + 2'd1] <= r1;
    end
  end

  echt_pkg::result_t head;
  assign head          = q_mem[rd_ptr_q];
  assign m_axis_tuser  = head.action;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {7'b0, head.read_value, head.ok, head.out_byte, head.port};

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(echt_pkg::Q_DEPTH))
    else $error("result queue overflow");

  // A completion pushed into the queue leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((n_res == 2'd1 && r0.action == echt_pkg::ACT_DONE) ||
     (n_res == 2'd2 && r1.action == echt_pkg::ACT_DONE)) |=> phase_q == PH_IDLE)
    else $error("completion without return to idle");

  // A fresh request while idle always yields exactly one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_kind && phase_q == PH_IDLE) |-> n_res == 2'd1)
    else $error("request start result count");

  // Waiting on the data byte follows a port read of the data port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_DATA && phase_d == PH_DATA) |-> (n_res == 2'd1 &&
      r0.action == echt_pkg::ACT_READ && r0.port == data_port_q))
    else $error("data phase entered without data port read");

endmodule

`default_nettype wire
